// ----- rtl/modular_exponentiation_defines.svh -----
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`define MEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
  `MEXP_ASSERT(label, (ante) |-> (cons), msg)

`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  `MEXP_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, register indexes, reset values and controller/datapath types.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned FIELD_WIDTH     = 32;
  localparam int unsigned CFG_INDEX_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 8'd1;

  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'd2;
  localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd0;

  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_MUL    = 2'd1,
    OP_SQR    = 2'd2
  } op_e;

  typedef struct packed {
    logic load_item;
    logic start;
    op_e  op;
    logic acc_load;
    logic base_load;
    logic exp_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic exp_zero;
    logic exp_lsb;
    logic mul_done;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/mexp_ifs.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for configuration writes, base values and results.
// ----------------------------------------------------------------------------
interface mexp_cfg_if import mexp_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [FIELD_WIDTH-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface mexp_base_if import mexp_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] base_value;

  modport source (output valid, base_value, input ready);
  modport sink   (input valid, base_value, output ready);
endinterface

interface mexp_result_if import mexp_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] power_result;

  modport source (output valid, power_result, input ready);
  modport sink   (input valid, power_result, output ready);
endinterface

// ----- rtl/mexp_mulmod.sv -----
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Interleaved shift-add a*b mod n, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [OPERAND_WIDTH-1:0] a_i,
  input  logic [OPERAND_WIDTH-1:0] b_i,
  input  logic [OPERAND_WIDTH-1:0] n_i,
  output logic                     done_o,
  output logic [OPERAND_WIDTH-1:0] result_o
);

  localparam int unsigned CntWidth = $clog2(OPERAND_WIDTH);
  localparam int unsigned AccWidth = OPERAND_WIDTH + 2;

  logic [OPERAND_WIDTH-1:0] a_q, b_q, r_q;
  logic [CntWidth-1:0]      cnt_q;
  logic                     run_q, done_q;

  logic [AccWidth-1:0] sum, n_one, n_two, red;

  always_comb begin
    n_one = {2'b00, n_i};
    n_two = {1'b0, n_i, 1'b0};
    sum   = {1'b0, r_q, 1'b0} + (a_q[OPERAND_WIDTH-1] ? {2'b00, b_q} : '0);
    if (sum >= n_two) begin
      red = sum - n_two;
    end else if (sum >= n_one) begin
      red = sum - n_one;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (run_q) begin
      a_q <= {a_q[OPERAND_WIDTH-2:0], 1'b0};
      r_q <= red[OPERAND_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntWidth'(OPERAND_WIDTH - 1);
      end else if (run_q) begin
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule

// ----- rtl/mexp_datapath.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Config registers, operand registers, shared multiplier and result register.
// ----------------------------------------------------------------------------
module mexp_datapath import mexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output status_t                    status_o,
  input  logic                       cfg_valid_i,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [FIELD_WIDTH-1:0]     cfg_data_i,
  input  logic [FIELD_WIDTH-1:0]     base_value_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [FIELD_WIDTH-1:0]     power_result_o
);

  logic [OPERAND_WIDTH-1:0] modulus_q, exponent_q;
  logic [OPERAND_WIDTH-1:0] n_q, e_q, base_q, acc_q, out_data_q;
  logic                     out_valid_q;

  logic [OPERAND_WIDTH-1:0] mm_a, mm_b, mm_result;
  logic                     mm_done;
  logic                     n_small;

  assign n_small = (n_q[OPERAND_WIDTH-1:1] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= MODULUS_RESET[OPERAND_WIDTH-1:0];
      exponent_q <= EXPONENT_RESET[OPERAND_WIDTH-1:0];
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODULUS:  modulus_q  <= cfg_data_i[OPERAND_WIDTH-1:0];
        REG_EXPONENT: exponent_q <= cfg_data_i[OPERAND_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_REDUCE: begin
        mm_a = base_q;
        mm_b = OPERAND_WIDTH'(1);
      end
      OP_MUL: begin
        mm_a = acc_q;
        mm_b = base_q;
      end
      default: begin
        mm_a = base_q;
        mm_b = base_q;
      end
    endcase
  end

  mexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .n_i     (n_q),
    .done_o  (mm_done),
    .result_o(mm_result)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      n_q    <= modulus_q;
      e_q    <= exponent_q;
      base_q <= base_value_i[OPERAND_WIDTH-1:0];
      acc_q  <= OPERAND_WIDTH'(1);
    end else begin
      if (cmd_i.base_load) begin
        base_q <= mm_result;
      end
      if (cmd_i.acc_load) begin
        acc_q <= mm_result;
      end
      if (cmd_i.exp_shift) begin
        e_q <= e_q >> 1;
      end
    end
    if (cmd_i.out_load) begin
      out_data_q <= n_small ? '0 : acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.n_small  = n_small;
  assign status_o.exp_zero = (e_q == '0);
  assign status_o.exp_lsb  = e_q[0];
  assign status_o.mul_done = mm_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign power_result_o = FIELD_WIDTH'(out_data_q);

endmodule

// ----- rtl/mexp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences reduction, multiply and square steps over the exponent bits.
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_PREP      = 9'b000000010,
    ST_WAIT_RED  = 9'b000000100,
    ST_CHECK     = 9'b000001000,
    ST_START_MUL = 9'b000010000,
    ST_WAIT_MUL  = 9'b000100000,
    ST_START_SQR = 9'b001000000,
    ST_WAIT_SQR  = 9'b010000000,
    ST_OUT       = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.op = OP_REDUCE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.n_small) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.start = 1'b1;
          state_d     = ST_WAIT_RED;
        end
      end
      ST_WAIT_RED: begin
        if (status_i.mul_done) begin
          cmd_o.base_load = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.exp_zero) begin
          state_d = ST_OUT;
        end else if (status_i.exp_lsb) begin
          state_d = ST_START_MUL;
        end else begin
          state_d = ST_START_SQR;
        end
      end
      ST_START_MUL: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_MUL;
        state_d     = ST_WAIT_MUL;
      end
      ST_WAIT_MUL: begin
        cmd_o.op = OP_MUL;
        if (status_i.mul_done) begin
          cmd_o.acc_load = 1'b1;
          state_d        = ST_START_SQR;
        end
      end
      ST_START_SQR: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_SQR;
        state_d     = ST_WAIT_SQR;
      end
      ST_WAIT_SQR: begin
        cmd_o.op = OP_SQR;
        if (status_i.mul_done) begin
          cmd_o.base_load = 1'b1;
          cmd_o.exp_shift = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/modular_exponentiation.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation, right-to-left square-and-multiply, one base at a time
// Each step runs on the bit-serial mulmod: a reduction, then per exponent bit a
// multiply when the bit is set and a square. A modulus below two skips these and
// gives zero. A new base is taken only once the controller is back in idle, after
// the result is loaded. Reset: modulus 2, exponent 0, controller idle.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  mexp_cfg_if.sink      cfg_i,
  mexp_base_if.sink     in_i,
  mexp_result_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  mexp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mexp_datapath #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .base_value_i  (in_i.base_value),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .power_result_o(out_o.power_result)
  );

  `MEXP_ASSERT_IMP(a_load_free, cmd.out_load, status.out_free, "result overwritten")
  `MEXP_ASSERT_NEXT(a_busy_after_req, in_i.valid && in_i.ready, !in_i.ready, "ready after request")
  `MEXP_ASSERT_IMP(a_update_on_done, cmd.acc_load || cmd.base_load, status.mul_done, "early update")

endmodule
